[hw/rtl/lwe_decrypt_round_macros.svh]
// ---------------------------------------------------------------------------
// lwe_decrypt_round assertion macros
// Immediate-consequence and next-cycle checks, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef LWE_DECRYPT_ROUND_MACROS_SVH
`define LWE_DECRYPT_ROUND_MACROS_SVH

`ifndef SYNTHESIS
`define LWEDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwe_decrypt_round: check failed");
`define LWEDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwe_decrypt_round: check failed");
`else
`define LWEDR_ASSERT_IMP(lbl, ante, cons)
`define LWEDR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/lwedr_pkg.sv]
// ---------------------------------------------------------------------------
// lwedr_pkg
// Shared codes, sizes and sequencer states of the LWE decryption block.
// ---------------------------------------------------------------------------
package lwedr_pkg;

    localparam int DEF_KEY_LENGTH = 1024;
    localparam int DIV_STEPS      = 64;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_MASK = 2'd1;
    localparam logic [1:0] OP_BODY = 2'd2;

    localparam logic [1:0] CFG_CIPHER_MOD = 2'd0;
    localparam logic [1:0] CFG_PLAIN_MOD  = 2'd1;
    localparam logic [1:0] CFG_ROUND_MODE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_RD,
        S_A_MUL,
        S_A_PMOD,
        S_A_ACC,
        S_B_INNER,
        S_B_R,
        S_B_MRT,
        S_B_K,
        S_B_KDIV,
        S_B_PLAIN,
        S_B_PDIV,
        S_B_BACK,
        S_B_BDIV0,
        S_B_BDIV,
        S_B_OUT
    } state_t;

endpackage

[hw/rtl/lwe_decrypt_round.sv]
// One item at a time: a new key, mask or body is taken only in the idle state.
// Mask and body processing runs on the shared 64-step restoring divider (two runs
// per coefficient, five per body) and the registered shared multiplier.
// Reset: asynchronous, active low; clears control, accumulator and registers
// (q=1024, t=4, mode 0). Key store contents are undefined until written.
// ---------------------------------------------------------------------------
// lwe_decrypt_round
// LWE decryption: key load, modular inner product, rounding and noise.
// ---------------------------------------------------------------------------
`include "lwe_decrypt_round_macros.svh"

module lwe_decrypt_round #(
    parameter int KEY_LENGTH = lwedr_pkg::DEF_KEY_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [9:0]  index,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] plaintext,
    output logic signed [31:0] noise
);
    import lwedr_pkg::*;

    localparam int AW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

    state_t state_reg, state_next;

    logic [31:0] cmod_reg;
    logic [16:0] tmod_reg;
    logic        mode_reg;

    logic [31:0] key_mem [KEY_LENGTH];
    logic [31:0] key_rd_reg;

    logic [31:0] val_reg;
    logic [31:0] acc_reg;
    logic [31:0] r_reg;
    logic [17:0] k_reg;
    logic [15:0] plain_reg;
    logic [63:0] prod_reg;

    logic [32:0] div_rem_reg;
    logic [63:0] div_quo_reg;
    logic [32:0] div_den_reg;
    logic [6:0]  div_cnt_reg;

    logic        out_valid_reg;
    logic [15:0] out_plain_reg;
    logic [31:0] out_noise_reg;

    logic        in_fire, idx_ok, div_done, out_free, out_load;
    logic [32:0] q_eff, q_half;
    logic [16:0] t_eff;
    logic [33:0] rsum, rs;

    logic        div_start;
    logic [63:0] div_num;
    logic [32:0] div_den_in;
    logic        mul_en;
    logic [32:0] mul_a, mul_b;
    logic [33:0] div_shift;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign idx_ok    = (32'(index) < 32'(KEY_LENGTH));
    assign div_done  = (div_cnt_reg == 7'd0);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_B_OUT) && out_free;

    assign q_eff  = (cmod_reg == 32'd0) ? {1'b1, 32'd0} : {1'b0, cmod_reg};
    assign q_half = q_eff >> 1;
    assign t_eff  = (tmod_reg == 17'd0) ? 17'd1 : tmod_reg;
    assign rsum   = 34'(r_reg) + 34'(q_eff >> 3);
    assign rs     = (rsum >= 34'(q_eff)) ? rsum - 34'(q_eff) : rsum;

    assign out_valid = out_valid_reg;
    assign plaintext = out_plain_reg;
    assign noise     = out_noise_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmod_reg <= 32'd1024;
            tmod_reg <= 17'd4;
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CIPHER_MOD: cmod_reg <= cfg_data;
                CFG_PLAIN_MOD:  tmod_reg <= cfg_data[16:0];
                CFG_ROUND_MODE: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (in_fire && op == OP_KEY && idx_ok)
            key_mem[AW'(index)] <= value;
        key_rd_reg <= key_mem[AW'(index)];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && op == OP_MASK && idx_ok)
                    state_next = S_KEY_RD;
                else if (in_fire && op == OP_BODY)
                    state_next = S_B_INNER;
            end
            S_KEY_RD:  state_next = S_A_MUL;
            S_A_MUL:   state_next = S_A_PMOD;
            S_A_PMOD:  if (div_done) state_next = S_A_ACC;
            S_A_ACC:   if (div_done) state_next = S_IDLE;
            S_B_INNER: if (div_done) state_next = S_B_R;
            S_B_R:     if (div_done) state_next = S_B_MRT;
            S_B_MRT:   state_next = S_B_K;
            S_B_K:     state_next = S_B_KDIV;
            S_B_KDIV:  if (div_done) state_next = S_B_PLAIN;
            S_B_PLAIN: state_next = S_B_PDIV;
            S_B_PDIV:  if (div_done) state_next = S_B_BACK;
            S_B_BACK:  state_next = S_B_BDIV0;
            S_B_BDIV0: state_next = S_B_BDIV;
            S_B_BDIV:  if (div_done) state_next = S_B_OUT;
            S_B_OUT:   if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // unit operand selection
    always_comb
    begin
        div_start  = 1'b0;
        div_num    = prod_reg;
        div_den_in = q_eff;
        mul_en     = 1'b0;
        mul_a      = 33'(val_reg);
        mul_b      = 33'(key_rd_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = in_fire && op == OP_BODY;
                div_num   = 64'(acc_reg);
            end
            S_KEY_RD: mul_en = 1'b1;
            S_A_MUL:  div_start = 1'b1;
            S_A_PMOD:
            begin
                div_start = div_done;
                div_num   = 64'(acc_reg) + 64'(div_rem_reg);
            end
            S_B_INNER:
            begin
                div_start = div_done;
                div_num   = 64'(val_reg) + 64'(q_eff) - 64'(div_rem_reg);
            end
            S_B_MRT:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(r_reg);
                mul_b  = 33'(t_eff);
            end
            S_B_K: div_start = 1'b1;
            S_B_PLAIN:
            begin
                div_start = 1'b1;
                if (mode_reg)
                begin
                    div_num    = 64'(k_reg);
                    div_den_in = 33'(t_eff);
                end
                else
                    div_num = 64'({rs, 2'b00});
            end
            S_B_BACK:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(k_reg);
                mul_b  = q_eff;
            end
            S_B_BDIV0:
            begin
                div_start  = 1'b1;
                div_den_in = 33'(t_eff);
            end
            default: ;
        endcase
    end

    assign div_shift = {div_rem_reg, div_quo_reg[63]};

    // shared restoring divider: one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= 7'd0;
            div_rem_reg <= 33'd0;
            div_den_reg <= 33'd1;
            div_quo_reg <= 64'd0;
        end
        else if (div_start)
        begin
            div_cnt_reg <= 7'(DIV_STEPS);
            div_rem_reg <= 33'd0;
            div_den_reg <= div_den_in;
            div_quo_reg <= div_num;
        end
        else if (!div_done)
        begin
            div_cnt_reg <= div_cnt_reg - 7'd1;
            if (div_shift >= 34'(div_den_reg))
            begin
                div_rem_reg <= 33'(div_shift - 34'(div_den_reg));
                div_quo_reg <= {div_quo_reg[62:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_shift[32:0];
                div_quo_reg <= {div_quo_reg[62:0], 1'b0};
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            val_reg <= value;
        if (mul_en)
            prod_reg <= 64'(mul_a * mul_b);
        if (state_reg == S_B_R && div_done)
            r_reg <= div_rem_reg[31:0];
        if (state_reg == S_B_KDIV && div_done)
            k_reg <= div_quo_reg[17:0] + 18'(div_rem_reg > q_half);
        if (state_reg == S_B_PDIV && div_done)
            plain_reg <= mode_reg ? div_rem_reg[15:0] : div_quo_reg[15:0];
        if (out_load)
        begin
            out_plain_reg <= plain_reg;
            out_noise_reg <= r_reg - div_quo_reg[31:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_A_ACC && div_done)
                acc_reg <= div_rem_reg[31:0];
            else if (out_load)
                acc_reg <= 32'd0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `LWEDR_ASSERT_IMP(a_rem_below_den, div_done, div_rem_reg < div_den_reg)
    `LWEDR_ASSERT_IMP(a_r_reduced, state_reg == S_B_MRT, 33'(r_reg) < q_eff)
    `LWEDR_ASSERT_NXT(a_acc_cleared, out_load, acc_reg == 32'd0 && out_valid_reg)

endmodule
